/* design/sliding_window_median_time_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window median core
// Shared concurrent assertion forms used by the core module.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TIME_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TIME_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWMT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWMT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/swmt_pkg.sv */
// ----------------------------------------------------------------------------
// swmt_pkg
// Sizes and shared types of the sliding window median core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swmt_pkg;

    localparam int WINDOW_SIZE = 11;
    localparam int TS_W        = 32;
    localparam int HELD_W      = 4;
    localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

    // Control that travels with one compare through the rank unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } rank_ctl_t;

endpackage

/* design/swmt_rank_unit.sv */
// ----------------------------------------------------------------------------
// swmt_rank_unit
// Shared comparator and rank accumulator: counts how many held entries sort
// ahead of the current candidate, with ties broken by slot index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmt_rank_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  swmt_pkg::rank_ctl_t             ctl,
    input  logic [swmt_pkg::TS_W-1:0]       cand,
    input  logic [swmt_pkg::TS_W-1:0]       other,
    input  logic [swmt_pkg::IDX_W-1:0]      cand_idx,
    input  logic [swmt_pkg::IDX_W-1:0]      other_idx,
    output logic [swmt_pkg::CNT_W-1:0]      rank
);

    logic                         ahead;
    logic [swmt_pkg::CNT_W-1:0]   acc_reg;
    logic [swmt_pkg::CNT_W-1:0]   acc_next;

    // The tie break on slot index makes every rank distinct, so exactly one
    // candidate owns each position of the sorted order.
    assign ahead = (other < cand) || ((other == cand) && (other_idx < cand_idx));

    always_comb begin
        acc_next = (ctl.first ? '0 : acc_reg) + swmt_pkg::CNT_W'(ahead);
    end

    assign rank = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.valid) begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* design/sliding_window_median_time_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_time_core
// Running median of the most recent block timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per block: s_tdata carries the 32-bit
//   timestamp. The block stores it in a window of the latest WINDOW_SIZE
//   entries (all entries while the window fills) and returns one result on
//   the master channel: the median of the held entries, the upper median for
//   an even count, together with the number of entries held.
//   s_tready is high only while the core is idle. After a request is taken,
//   the core finds the median by ranking each held entry against every other
//   one through a single comparator fed by a two-port window memory, and
//   takes no new request until the result of the item has been loaded into
//   the output register. The comparator pass thus sets the rate of items.
//   The result sits in an output register; a stalled receiver holds it there
//   while the core goes idle and takes the next request. A second result
//   waits in the core until the first one is taken.
//   Reset empties the window (count and oldest slot to zero) and clears both
//   valids; window contents need no clearing, since only written slots are
//   read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_median_time_core_defines.svh"

module sliding_window_median_time_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] timestamp
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] median_time, [35:32] held_count, zero fill
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam int W = swmt_pkg::WINDOW_SIZE;

    logic [1:0]                     state_reg;
    logic [swmt_pkg::CNT_W-1:0]     fill_reg;
    logic [swmt_pkg::IDX_W-1:0]     oldest_reg;
    logic [swmt_pkg::IDX_W-1:0]     i_reg;
    logic [swmt_pkg::IDX_W-1:0]     j_reg;
    logic [swmt_pkg::IDX_W-1:0]     i_d_reg;
    logic [swmt_pkg::IDX_W-1:0]     j_d_reg;
    swmt_pkg::rank_ctl_t            ctl_reg;
    logic                           found_reg;
    logic [swmt_pkg::TS_W-1:0]      res_reg;
    logic                           m_tvalid_reg;
    logic [swmt_pkg::TS_W-1:0]      m_median_reg;
    logic [swmt_pkg::HELD_W-1:0]    m_held_reg;

    logic [swmt_pkg::TS_W-1:0]      window_mem [W];
    logic [swmt_pkg::TS_W-1:0]      rd_a_reg;
    logic [swmt_pkg::TS_W-1:0]      rd_b_reg;

    logic                           accept;
    logic                           wr_en;
    logic [swmt_pkg::IDX_W-1:0]     wr_slot;
    logic [swmt_pkg::IDX_W-1:0]     last_idx;
    logic                           last_j;
    logic                           issue;
    logic [swmt_pkg::CNT_W-1:0]     half;
    logic [swmt_pkg::CNT_W-1:0]     rank;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept;
    assign wr_slot  = (fill_reg < swmt_pkg::CNT_W'(W)) ? swmt_pkg::IDX_W'(fill_reg) : oldest_reg;
    assign last_idx = swmt_pkg::IDX_W'(fill_reg - swmt_pkg::CNT_W'(1));
    assign last_j   = (j_reg == last_idx);
    assign issue    = (state_reg == ST_SCAN);
    assign half     = fill_reg >> 1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_held_reg, m_median_reg};

    // Window memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            window_mem[wr_slot] <= s_tdata;
        end
        rd_a_reg <= window_mem[i_reg];
        rd_b_reg <= window_mem[j_reg];
    end

    swmt_rank_unit u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_reg),
        .cand      (rd_a_reg),
        .other     (rd_b_reg),
        .cand_idx  (i_d_reg),
        .other_idx (j_d_reg),
        .rank      (rank)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            ctl_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In ST_OUT the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            ctl_reg.valid <= issue;
            ctl_reg.first <= (j_reg == '0);
            ctl_reg.last  <= last_j;
            i_d_reg       <= i_reg;
            j_d_reg       <= j_reg;

            // The candidate whose rank equals count/2 is the median.
            if (ctl_reg.valid && ctl_reg.last && (rank == half)) begin
                res_reg   <= rd_a_reg;
                found_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (fill_reg < swmt_pkg::CNT_W'(W)) begin
                            fill_reg <= fill_reg + swmt_pkg::CNT_W'(1);
                        end else if (oldest_reg == swmt_pkg::IDX_W'(W - 1)) begin
                            oldest_reg <= '0;
                        end else begin
                            oldest_reg <= oldest_reg + swmt_pkg::IDX_W'(1);
                        end
                        i_reg     <= '0;
                        j_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (last_j) begin
                        j_reg <= '0;
                        if (i_reg == last_idx) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            i_reg <= i_reg + swmt_pkg::IDX_W'(1);
                        end
                    end else begin
                        j_reg <= j_reg + swmt_pkg::IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_median_reg <= res_reg;
                        m_held_reg   <= swmt_pkg::HELD_W'(fill_reg);
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SWMT_ASSERT_NXT(a_accept_starts_scan, aclk, aresetn, accept, state_reg == ST_SCAN, "accepted request did not start a scan")
    `SWMT_ASSERT_IMP(a_fill_bounded, aclk, aresetn, 1'b1, fill_reg <= swmt_pkg::CNT_W'(W), "fill count exceeds window size")
    `SWMT_ASSERT_NXT(a_median_found, aclk, aresetn, state_reg == ST_DRAIN, found_reg, "scan ended without a median candidate")
    `SWMT_ASSERT_IMP(a_rank_in_scan, aclk, aresetn, ctl_reg.valid, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN), "compare in flight outside a scan")

endmodule
